[hw/rtl/nbt_pkg.sv]
// shared types and constants for the neighbor table block
// no dependencies; used by every module of the block
package nbt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;
  localparam logic [4:0]  REMOVED_MAX    = 5'd31;

  localparam logic [15:0] OWN_ADDR_RST  = 16'd1;
  localparam logic [15:0] TIMEOUT_RST   = 16'd50;
  localparam logic [15:0] HEARTBEAT_RST = 16'd5;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RECV  = 2'd1,
    CMD_SEND  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_HEARTBEAT = 3'd1,
    ACT_DELIVER   = 3'd2,
    ACT_TRANSMIT  = 3'd3,
    ACT_DROPPED   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    REG_OWN_ADDR  = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_HEARTBEAT = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_RECV,
    OP_TRANSMIT,
    OP_LOOPBACK,
    OP_DROP,
    OP_QUERY
  } op_kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_DONE
  } back_state_e;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] peer_address;
    logic [15:0] dest_address;
    logic        is_heartbeat;
    logic [7:0]  hop_count;
    logic        payload_empty;
  } nbt_in_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] out_source;
    logic [15:0] out_dest;
    logic [7:0]  out_hops;
    logic        out_heartbeat;
    logic        reachable;
    logic        table_overflow;
    logic [4:0]  removed_count;
  } nbt_out_t;

  typedef struct packed {
    logic [15:0] own_address;
    logic [15:0] timeout_ticks;
    logic [15:0] heartbeat_ticks;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    op_kind_e    kind;
    logic [15:0] peer;
    logic [15:0] dest;
    logic [7:0]  hops;
    logic        hb;
    logic        deliver;
  } op_t;

endpackage

[hw/rtl/nbt_front.sv]
// front stage: accepts requests and classifies them into table operations
// depends on nbt_pkg
module nbt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nbt_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nbt_pkg::nbt_in_t in_data_i,
  output logic           op_valid_o,
  input  logic           op_ready_i,
  output nbt_pkg::op_t   op_o
);

  logic         front_vld_q, front_vld_d;
  nbt_pkg::op_t front_op_q, front_op_d;
  logic         accept;

  assign in_ready_o = !front_vld_q || op_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign front_vld_d = accept || (front_vld_q && !op_ready_i);

  always_comb begin
    front_op_d         = '0;
    front_op_d.peer    = in_data_i.peer_address;
    front_op_d.dest    = in_data_i.dest_address;
    front_op_d.hb      = in_data_i.is_heartbeat;
    front_op_d.hops    = in_data_i.hop_count;
    front_op_d.deliver = 1'b0;
    unique case (in_data_i.command)
      nbt_pkg::CMD_TICK: begin
        front_op_d.kind = nbt_pkg::OP_TICK;
      end
      nbt_pkg::CMD_RECV: begin
        front_op_d.kind    = nbt_pkg::OP_RECV;
        front_op_d.deliver = !in_data_i.is_heartbeat &&
                             (in_data_i.dest_address == cfg_i.own_address ||
                              in_data_i.dest_address == nbt_pkg::BROADCAST_ADDR);
        // delivered hop count, floored at zero
        front_op_d.hops    = (in_data_i.hop_count != 8'd0) ?
                             in_data_i.hop_count - 8'd1 : 8'd0;
      end
      nbt_pkg::CMD_SEND: begin
        if (in_data_i.payload_empty) begin
          front_op_d.kind = nbt_pkg::OP_DROP;
        end else if (in_data_i.dest_address == cfg_i.own_address) begin
          front_op_d.kind = nbt_pkg::OP_LOOPBACK;
        end else begin
          front_op_d.kind = nbt_pkg::OP_TRANSMIT;
        end
      end
      nbt_pkg::CMD_QUERY: begin
        front_op_d.kind = nbt_pkg::OP_QUERY;
      end
      default: begin
        front_op_d.kind = nbt_pkg::OP_QUERY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_vld_q <= 1'b0;
    end else begin
      front_vld_q <= front_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_op_q <= front_op_d;
    end
  end

  assign op_valid_o = front_vld_q;
  assign op_o       = front_op_q;

endmodule

[hw/rtl/nbt_queue.sv]
// short fifo of classified operations between front and back
// depends on nbt_pkg
module nbt_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  nbt_pkg::op_t push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output nbt_pkg::op_t pop_data_o
);

  localparam int unsigned PTR_W = (nbt_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(nbt_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(nbt_pkg::QUEUE_DEPTH + 1);

  nbt_pkg::op_t     slots_q [nbt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = count_q != CNT_W'(nbt_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(nbt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(nbt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/nbt_back.sv]
// back end: executes operations against the neighbor table, scanning one entry a cycle
// depends on nbt_pkg; holds the address and last-seen memories and the result register
module nbt_back #(
  parameter int unsigned TABLE_DEPTH = nbt_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nbt_pkg::cfg_t     cfg_i,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  nbt_pkg::op_t      op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nbt_pkg::nbt_out_t out_data_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  nbt_pkg::back_state_e state_q, state_d;
  nbt_pkg::op_t         op_q, op_d;
  nbt_pkg::nbt_out_t    res_q, res_d;
  logic                 res_vld_q, res_vld_d;

  logic [31:0] time_q, time_d;
  logic [31:0] last_tx_q, last_tx_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;

  logic [15:0] addr_mem [TABLE_DEPTH];
  logic [31:0] seen_mem [TABLE_DEPTH];
  logic [15:0] addr_rd_q;
  logic [31:0] seen_rd_q;

  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             match_q, match_d;
  logic [IDX_W-1:0] match_idx_q, match_idx_d;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [4:0]       removed_q, removed_d;

  logic             issue;
  logic [IDX_W-1:0] rd_idx;
  logic             seen_we, addr_we;
  logic [IDX_W-1:0] wr_idx;

  assign rd_idx = rd_cnt_q[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    res_d       = res_q;
    res_vld_d   = res_vld_q && !out_ready_i;
    time_d      = time_q;
    last_tx_d   = last_tx_q;
    valid_d     = valid_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    removed_d   = removed_q;
    op_ready_o  = 1'b0;
    issue       = 1'b0;
    seen_we     = 1'b0;
    addr_we     = 1'b0;
    wr_idx      = match_idx_q;

    unique case (state_q)
      nbt_pkg::S_IDLE: begin
        op_ready_o = !res_vld_q;
        if (op_valid_i && !res_vld_q) begin
          op_d    = op_i;
          state_d = nbt_pkg::S_START;
        end
      end

      nbt_pkg::S_START: begin
        res_d     = '0;
        rd_cnt_d  = '0;
        match_d   = 1'b0;
        free_d    = 1'b0;
        removed_d = '0;
        case (op_q.kind) inside
          nbt_pkg::OP_TICK: begin
            time_d = time_q + 32'd1;
            if ((time_d - last_tx_q) > {16'd0, cfg_i.heartbeat_ticks}) begin
              last_tx_d           = time_d;
              res_d.action        = nbt_pkg::ACT_HEARTBEAT;
              res_d.out_source    = cfg_i.own_address;
              res_d.out_dest      = nbt_pkg::BROADCAST_ADDR;
              res_d.out_heartbeat = 1'b1;
            end
            state_d = nbt_pkg::S_SCAN;
          end
          nbt_pkg::OP_RECV, nbt_pkg::OP_QUERY: begin
            state_d = nbt_pkg::S_SCAN;
          end
          nbt_pkg::OP_TRANSMIT, nbt_pkg::OP_LOOPBACK: begin
            res_d.action        = (op_q.kind == nbt_pkg::OP_TRANSMIT) ?
                                  nbt_pkg::ACT_TRANSMIT : nbt_pkg::ACT_DELIVER;
            res_d.out_source    = cfg_i.own_address;
            res_d.out_dest      = op_q.dest;
            res_d.out_hops      = op_q.hops;
            res_d.out_heartbeat = op_q.hb;
            if (op_q.kind == nbt_pkg::OP_TRANSMIT) begin
              last_tx_d = time_q;
            end
            res_vld_d = 1'b1;
            state_d   = nbt_pkg::S_IDLE;
          end
          nbt_pkg::OP_DROP: begin
            res_d.action = nbt_pkg::ACT_DROPPED;
            res_vld_d    = 1'b1;
            state_d      = nbt_pkg::S_IDLE;
          end
          default: begin
            state_d = nbt_pkg::S_IDLE;
          end
        endcase
      end

      nbt_pkg::S_SCAN: begin
        // read one entry a cycle, compare it the cycle after
        if (rd_cnt_q < CNT_W'(TABLE_DEPTH)) begin
          issue     = 1'b1;
          rd_cnt_d  = rd_cnt_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx;
        end
        if (cmp_vld_q) begin
          if (op_q.kind == nbt_pkg::OP_TICK) begin
            if (valid_q[cmp_idx_q] &&
                (time_q - seen_rd_q) > {16'd0, cfg_i.timeout_ticks}) begin
              valid_d[cmp_idx_q] = 1'b0;
              if (removed_q != nbt_pkg::REMOVED_MAX) begin
                removed_d = removed_q + 5'd1;
              end
            end
          end else begin
            if (valid_q[cmp_idx_q] && addr_rd_q == op_q.peer && !match_q) begin
              match_d     = 1'b1;
              match_idx_d = cmp_idx_q;
            end
            if (!valid_q[cmp_idx_q] && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = cmp_idx_q;
            end
          end
          if (cmp_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
            state_d = nbt_pkg::S_DONE;
          end
        end
      end

      nbt_pkg::S_DONE: begin
        case (op_q.kind) inside
          nbt_pkg::OP_TICK: begin
            res_d.removed_count = removed_q;
          end
          nbt_pkg::OP_QUERY: begin
            res_d.reachable = match_q;
          end
          nbt_pkg::OP_RECV: begin
            if (match_q) begin
              seen_we = 1'b1;
              wr_idx  = match_idx_q;
            end else if (free_q) begin
              seen_we             = 1'b1;
              addr_we             = 1'b1;
              wr_idx              = free_idx_q;
              valid_d[free_idx_q] = 1'b1;
            end else begin
              res_d.table_overflow = 1'b1;
            end
            if (op_q.deliver) begin
              res_d.action        = nbt_pkg::ACT_DELIVER;
              res_d.out_source    = op_q.peer;
              res_d.out_dest      = op_q.dest;
              res_d.out_hops      = op_q.hops;
              res_d.out_heartbeat = 1'b0;
            end
          end
          default: begin
            res_d = res_q;
          end
        endcase
        res_vld_d = 1'b1;
        state_d   = nbt_pkg::S_IDLE;
      end

      default: begin
        state_d = nbt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nbt_pkg::S_IDLE;
      res_vld_q <= 1'b0;
      time_q    <= '0;
      last_tx_q <= '0;
      valid_q   <= '0;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      removed_q <= '0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      time_q    <= time_d;
      last_tx_q <= last_tx_d;
      valid_q   <= valid_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_vld_q <= cmp_vld_d;
      match_q   <= match_d;
      free_q    <= free_d;
      removed_q <= removed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    res_q       <= res_d;
    cmp_idx_q   <= cmp_idx_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
  end

  // table memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[wr_idx] <= time_q;
    end
    if (addr_we) begin
      addr_mem[wr_idx] <= op_q.peer;
    end
    if (issue) begin
      addr_rd_q <= addr_mem[rd_idx];
      seen_rd_q <= seen_mem[rd_idx];
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

[hw/rtl/neighbor_table_with_aging_core.sv]
// path: a local send passes the front register, the queue slot, the back end start state and
// the result register; ticks, received headers and queries also pass the one-entry-per-cycle
// table scan and the done state; the back end works on one request at a time and takes its next
// request the cycle after its result is taken
// reset: async active low; clears time, transmit time, all entry valid bits, queues and
// result; configuration returns to address 1, timeout 50, heartbeat 5
module neighbor_table_with_aging_core #(
  parameter int unsigned TABLE_DEPTH = nbt_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nbt_pkg::nbt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nbt_pkg::nbt_out_t out_data_o
);

  nbt_pkg::cfg_t cfg_q, cfg_d;

  logic         fr_valid, fr_ready;
  nbt_pkg::op_t fr_op;
  logic         q_valid, q_ready;
  nbt_pkg::op_t q_op;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        nbt_pkg::REG_OWN_ADDR:  cfg_d.own_address     = cfg_data_i;
        nbt_pkg::REG_TIMEOUT:   cfg_d.timeout_ticks   = cfg_data_i;
        nbt_pkg::REG_HEARTBEAT: cfg_d.heartbeat_ticks = cfg_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address     <= nbt_pkg::OWN_ADDR_RST;
      cfg_q.timeout_ticks   <= nbt_pkg::TIMEOUT_RST;
      cfg_q.heartbeat_ticks <= nbt_pkg::HEARTBEAT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nbt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .op_valid_o (fr_valid),
    .op_ready_i (fr_ready),
    .op_o       (fr_op)
  );

  nbt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_op),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_op)
  );

  nbt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (q_valid),
    .op_ready_o  (q_ready),
    .op_i        (q_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hw/rtl/nbt_checker.sv]
// port-level checks on the result channel of the neighbor table core
// depends on nbt_pkg; bound to neighbor_table_with_aging_core below
module nbt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input nbt_pkg::nbt_out_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  a_quiet_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.action == nbt_pkg::ACT_NONE ||
                    out_data_i.action == nbt_pkg::ACT_DROPPED) |->
    out_data_i.out_source == 16'd0 && out_data_i.out_dest == 16'd0 &&
    out_data_i.out_hops == 8'd0 && !out_data_i.out_heartbeat)
    else $error("header fields set without a header action");

  a_heartbeat_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.action == nbt_pkg::ACT_HEARTBEAT |->
    out_data_i.out_dest == nbt_pkg::BROADCAST_ADDR && out_data_i.out_hops == 8'd0 &&
    out_data_i.out_heartbeat && !out_data_i.reachable && !out_data_i.table_overflow)
    else $error("malformed heartbeat result");

  a_removed_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.removed_count != 5'd0 |->
    !out_data_i.reachable && !out_data_i.table_overflow &&
    (out_data_i.action == nbt_pkg::ACT_NONE ||
     out_data_i.action == nbt_pkg::ACT_HEARTBEAT))
    else $error("aging count on a non-tick result");

  a_overflow_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.table_overflow |->
    !out_data_i.reachable && (out_data_i.action == nbt_pkg::ACT_NONE ||
                              out_data_i.action == nbt_pkg::ACT_DELIVER))
    else $error("overflow flag on a result that is not a received header");

endmodule

bind neighbor_table_with_aging_core nbt_checker u_nbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
